// ===== rtl/dpbs_pkg.sv =====
package dpbs_pkg;

   // Item modes as they arrive on req_mode
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // Classified commands handed from the front end to the back end
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   // Frame sequencer states
   localparam logic [1:0] FS_PREAMBLE = 2'd0;
   localparam logic [1:0] FS_START    = 2'd1;
   localparam logic [1:0] FS_BYTE     = 2'd2;
   localparam logic [1:0] FS_END      = 2'd3;

   // Packet loader phases
   localparam logic [1:0] LP_IDLE    = 2'd0;
   localparam logic [1:0] LP_LOADING = 2'd1;
   localparam logic [1:0] LP_DISCARD = 2'd2;

   // Load status codes
   localparam logic [1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_NONE   = 2'd2;

   // Register map, indexed by address bit 2
   localparam logic CSR_PREAMBLE = 1'b0;
   localparam logic CSR_REPEAT   = 1'b1;

   localparam logic [4:0] PREAMBLE_RESET = 5'd14;
   localparam logic [3:0] REPEAT_RESET   = 4'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       last_byte;
   } cmd_type;

   typedef struct packed {
      logic [4:0] preamble_bits;
      logic [3:0] repeat_count;
   } cfg_type;

endpackage

// ===== rtl/dpbs_front.sv =====
module dpbs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             q_full,
   output logic             q_push,
   output dpbs_pkg::cmd_type q_cmd
);
   import dpbs_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign busy   = valid_ff && q_full;
   assign accept = start && !busy;
   assign q_push = valid_ff && !q_full;
   assign q_cmd  = cmd_ff;

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in         = 1'b1;
         cmd_in.data_byte = req_data_byte;
         cmd_in.last_byte = req_last_byte;
         case (req_mode)
            MODE_TICK:  cmd_in.op = OP_TICK;
            MODE_LOAD:  cmd_in.op = OP_LOAD;
            MODE_CLEAR: cmd_in.op = OP_CLEAR;
            default:    cmd_in.op = OP_NOP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== rtl/dpbs_queue.sv =====
module dpbs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dpbs_pkg::cmd_type cmd_in,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output dpbs_pkg::cmd_type cmd_out
);
   import dpbs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign cmd_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== rtl/dpbs_back.sv =====
module dpbs_back #(
   parameter int MAX_PACKETS = 8,
   parameter int MAX_BYTES   = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  dpbs_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  dpbs_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_strobe,
   output logic             rsp_track_bit,
   output logic             rsp_bit_valid,
   output logic [1:0]       rsp_load_status
);
   import dpbs_pkg::*;

   localparam int SW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int PW = $clog2(MAX_BYTES + 1);
   localparam int AW = $clog2(MAX_PACKETS * MAX_BYTES);
   localparam int DEPTH = MAX_PACKETS * MAX_BYTES;
   localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_PACKETS - 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_BYTES);

   // Packet byte store; contents past a slot's size are never read
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   logic [3:0]    count_ff [MAX_PACKETS];
   logic [3:0]    count_in [MAX_PACKETS];
   logic [PW-1:0] size_ff  [MAX_PACKETS];
   logic [PW-1:0] size_in  [MAX_PACKETS];

   logic [SW-1:0] active_ff, active_in;
   logic          idle_ff, idle_in;
   logic [PW-1:0] byte_pos_ff, byte_pos_in;
   logic [2:0]    bit_pos_ff, bit_pos_in;
   logic [7:0]    shift_ff, shift_in;
   logic          fresh_ff, fresh_in;
   logic [1:0]    frame_ff, frame_in;
   logic [4:0]    pre_left_ff, pre_left_in;
   logic [SW-1:0] load_slot_ff, load_slot_in;
   logic [PW-1:0] load_pos_ff, load_pos_in;
   logic [1:0]    phase_ff, phase_in;
   logic [SW-1:0] hint_ff, hint_in;

   logic          strobe_ff, strobe_in;
   logic          track_ff, track_in;
   logic          bvalid_ff, bvalid_in;
   logic [1:0]    status_ff, status_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    wr_data;

   logic [MAX_PACKETS-1:0] busy_vec, free_vec;
   logic [SW-1:0] frame_base;
   logic [SW:0]   frame_pick, free_pick;
   logic [PW-1:0] cur_size;
   logic [7:0]    cur_byte;
   logic          claim;
   logic [SW-1:0] slot_e;
   logic [PW-1:0] pos_e, pos_new;

   // Round-robin pick: first set bit at or above base, else first set bit overall
   function automatic logic [SW:0] rr_pick(input logic [MAX_PACKETS-1:0] vec,
                                            input logic [SW-1:0] base);
      logic [SW-1:0] hi_idx, lo_idx;
      logic          hi_hit, lo_hit;
      hi_idx = '0;
      lo_idx = '0;
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      for (int j = MAX_PACKETS - 1; j >= 0; j--) begin
         if (vec[j]) begin
            lo_hit = 1'b1;
            lo_idx = SW'(j);
            if (SW'(j) >= base) begin
               hi_hit = 1'b1;
               hi_idx = SW'(j);
            end
         end
      end
      return hi_hit ? {1'b1, hi_idx} : {lo_hit, lo_idx};
   endfunction

   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SW'(1);
   endfunction

   function automatic logic [AW-1:0] mem_addr(input logic [SW-1:0] s,
                                              input logic [PW-1:0] p);
      return AW'(AW'(s) * AW'(MAX_BYTES) + AW'(p));
   endfunction

   always_comb begin
      for (int i = 0; i < MAX_PACKETS; i++) begin
         busy_vec[i] = (count_ff[i] != 4'd0);
         free_vec[i] = (count_ff[i] == 4'd0);
      end
   end

   assign frame_base = slot_next(active_ff);
   assign frame_pick = rr_pick(busy_vec, frame_base);
   assign free_pick  = rr_pick(free_vec, hint_ff);
   assign cur_size   = idle_ff ? '0 : size_ff[active_ff];
   assign cur_byte   = fresh_ff ? rd_data_ff : shift_ff;
   assign claim      = (phase_ff != LP_LOADING);
   assign slot_e     = claim ? free_pick[SW-1:0] : load_slot_ff;
   assign pos_e      = claim ? '0 : load_pos_ff;
   assign q_pop      = !q_empty;

   always_comb begin
      count_in     = count_ff;
      size_in      = size_ff;
      active_in    = active_ff;
      idle_in      = idle_ff;
      byte_pos_in  = byte_pos_ff;
      bit_pos_in   = bit_pos_ff;
      shift_in     = shift_ff;
      fresh_in     = fresh_ff;
      frame_in     = frame_ff;
      pre_left_in  = pre_left_ff;
      load_slot_in = load_slot_ff;
      load_pos_in  = load_pos_ff;
      phase_in     = phase_ff;
      hint_in      = hint_ff;
      strobe_in    = q_pop;
      track_in     = 1'b0;
      bvalid_in    = 1'b0;
      status_in    = STATUS_NONE;
      rd_en        = 1'b0;
      rd_addr      = mem_addr(active_ff, byte_pos_ff);
      wr_en        = 1'b0;
      wr_addr      = mem_addr(slot_e, pos_e);
      wr_data      = q_cmd.data_byte;
      pos_new      = pos_e;

      if (q_pop) begin
         case (q_cmd.op)
            OP_TICK: begin
               bvalid_in = 1'b1;
               case (frame_ff)
                  FS_PREAMBLE: begin
                     track_in = 1'b1;
                     if (pre_left_ff != 5'd0) begin
                        pre_left_in = pre_left_ff - 5'd1;
                     end else begin
                        frame_in = FS_START;
                     end
                  end
                  FS_START: begin
                     track_in = 1'b0;
                     if (byte_pos_ff >= cur_size) begin
                        frame_in    = FS_PREAMBLE;
                        pre_left_in = cfg.preamble_bits;
                        byte_pos_in = '0;
                        idle_in     = !frame_pick[SW];
                        if (frame_pick[SW]) begin
                           active_in = frame_pick[SW-1:0];
                           count_in[frame_pick[SW-1:0]] =
                              count_ff[frame_pick[SW-1:0]] - 4'd1;
                        end
                     end else begin
                        // fetch the byte; it lands in rd_data_ff for the next bit
                        rd_en       = 1'b1;
                        fresh_in    = 1'b1;
                        byte_pos_in = byte_pos_ff + PW'(1);
                        bit_pos_in  = 3'd0;
                        frame_in    = FS_BYTE;
                     end
                  end
                  FS_BYTE: begin
                     track_in = cur_byte[7];
                     fresh_in = 1'b0;
                     if (bit_pos_ff == 3'd7) begin
                        frame_in = (byte_pos_ff >= cur_size) ? FS_END : FS_START;
                     end else begin
                        bit_pos_in = bit_pos_ff + 3'd1;
                        shift_in   = {cur_byte[6:0], 1'b0};
                     end
                  end
                  default: begin
                     track_in    = 1'b1;
                     frame_in    = FS_PREAMBLE;
                     pre_left_in = cfg.preamble_bits;
                     byte_pos_in = '0;
                     idle_in     = !frame_pick[SW];
                     if (frame_pick[SW]) begin
                        active_in = frame_pick[SW-1:0];
                        count_in[frame_pick[SW-1:0]] =
                           count_ff[frame_pick[SW-1:0]] - 4'd1;
                     end
                  end
               endcase
            end
            OP_LOAD: begin
               if (phase_ff == LP_DISCARD) begin
                  status_in = STATUS_REJECT;
                  if (q_cmd.last_byte) begin
                     phase_in = LP_IDLE;
                  end
               end else if (claim && !free_pick[SW]) begin
                  status_in = STATUS_REJECT;
                  phase_in  = q_cmd.last_byte ? LP_IDLE : LP_DISCARD;
               end else begin
                  status_in    = STATUS_ACCEPT;
                  load_slot_in = slot_e;
                  phase_in     = LP_LOADING;
                  // drop bytes past the slot length
                  if (pos_e < POS_LIMIT) begin
                     wr_en   = 1'b1;
                     pos_new = pos_e + PW'(1);
                  end
                  load_pos_in = pos_new;
                  if (q_cmd.last_byte) begin
                     size_in[slot_e]  = pos_new;
                     count_in[slot_e] = cfg.repeat_count;
                     hint_in          = slot_next(slot_e);
                     phase_in         = LP_IDLE;
                  end
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < MAX_PACKETS; i++) begin
                  count_in[i] = 4'd0;
                  size_in[i]  = '0;
               end
               phase_in    = LP_IDLE;
               load_pos_in = '0;
            end
            default: begin
               status_in = STATUS_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PACKETS; i++) begin
            count_ff[i] <= 4'd0;
            size_ff[i]  <= '0;
         end
         active_ff    <= '0;
         idle_ff      <= 1'b1;
         byte_pos_ff  <= '0;
         bit_pos_ff   <= 3'd0;
         shift_ff     <= 8'd0;
         fresh_ff     <= 1'b0;
         frame_ff     <= FS_PREAMBLE;
         pre_left_ff  <= PREAMBLE_RESET;
         load_slot_ff <= '0;
         load_pos_ff  <= '0;
         phase_ff     <= LP_IDLE;
         hint_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         size_ff      <= size_in;
         active_ff    <= active_in;
         idle_ff      <= idle_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
         shift_ff     <= shift_in;
         fresh_ff     <= fresh_in;
         frame_ff     <= frame_in;
         pre_left_ff  <= pre_left_in;
         load_slot_ff <= load_slot_in;
         load_pos_ff  <= load_pos_in;
         phase_ff     <= phase_in;
         hint_ff      <= hint_in;
         strobe_ff    <= strobe_in;
      end
      track_ff  <= track_in;
      bvalid_ff <= bvalid_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_track_bit   = track_ff;
   assign rsp_bit_valid   = bvalid_ff;
   assign rsp_load_status = status_ff;

endmodule

// ===== rtl/dcc_packet_bit_sequencer.sv =====
// DCC packet bit sequencer. Issue an item with start while busy is low; it is
// taken into a front register, queued, and executed by the back end, which
// finishes one item per clock. Each item yields one result, shown for a single
// cycle with rsp_strobe after the front register, the queue and the result
// register; results come in item order and must be captured when strobed,
// since the receiver cannot stall. Sustained rate is one item per cycle, set
// by one back end step over packet table, frame sequencer and byte store port.
// busy rises only if the two-entry queue fills, which a steady back end
// prevents. The byte store is not cleared; slot sizes guard every read.
// Registers: 0x0 preamble_bits (5 bits, reset 14), 0x4 repeat_count (4 bits,
// reset 4); write them only while no item is in flight.
module dcc_packet_bit_sequencer #(
   parameter int MAX_PACKETS = 8,
   parameter int MAX_BYTES   = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_strobe,
   output logic        rsp_track_bit,
   output logic        rsp_bit_valid,
   output logic [1:0]  rsp_load_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dpbs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   cmd_type push_cmd, head_cmd;
   logic    q_push, q_pop, q_full, q_empty;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_PREAMBLE: cfg_in.preamble_bits = pwdata[4:0];
            CSR_REPEAT:   cfg_in.repeat_count  = pwdata[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_bits <= PREAMBLE_RESET;
         cfg_ff.repeat_count  <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_PREAMBLE: prdata = {27'd0, cfg_ff.preamble_bits};
         CSR_REPEAT:   prdata = {28'd0, cfg_ff.repeat_count};
         default:      prdata = 32'd0;
      endcase
   end

   dpbs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   dpbs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .cmd_out (head_cmd)
   );

   dpbs_back #(
      .MAX_PACKETS (MAX_PACKETS),
      .MAX_BYTES   (MAX_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_track_bit   (rsp_track_bit),
      .rsp_bit_valid   (rsp_bit_valid),
      .rsp_load_status (rsp_load_status)
   );

endmodule

// ===== rtl/dpbs_checker.sv =====
module dpbs_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_track_bit,
   input logic       rsp_bit_valid,
   input logic [1:0] rsp_load_status
);
   import dpbs_pkg::*;

   // a tick result never carries a load status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bit_valid) |-> (rsp_load_status == STATUS_NONE))
      else $error("tick result carries a load status");

   // a one on the track only comes with a tick result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_track_bit) |-> rsp_bit_valid)
      else $error("track bit set on a non-tick result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_load_status == STATUS_ACCEPT ||
                      rsp_load_status == STATUS_REJECT ||
                      rsp_load_status == STATUS_NONE))
      else $error("undefined load status");

   // nothing in flight right after reset
   assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_strobe))
      else $error("busy or result right after reset");

endmodule

bind dcc_packet_bit_sequencer dpbs_checker u_dpbs_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_track_bit   (rsp_track_bit),
   .rsp_bit_valid   (rsp_bit_valid),
   .rsp_load_status (rsp_load_status)
);
